// ----- src/bsc_pkg.sv -----
`default_nettype none

package bsc_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int VAL_W        = 32;
  localparam int PASS_W       = 4;
  localparam int CMP_W        = 7;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_FIELDS_W = VAL_W + PASS_W + CMP_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PASS_W-1:0]       pass_t;
  typedef logic [CMP_W-1:0]        cmp_t;

endpackage

`default_nettype wire

// ----- src/bubble_sort_counted.sv -----
// Counted bubble sort of signed 32-bit values.
// Input channel (in_*): one value per item in in_tdata[31:0], in_tlast on the
// final value of a set. Up to MAX_ELEMENTS values are kept; further values are
// dropped and flagged, and a dropped value with in_tlast still closes the set.
// Loading takes one item per cycle; in_tready is low from the last item of a
// set until the final result of that set has been taken.
// Sorting runs on a single 1R1W store with registered read. A pass over L
// elements carries the running maximum up the store: ST_PSTART reads the
// first element, ST_FIRST loads it as the carry, ST_CMP compares the carry
// with each next element and writes the smaller one back, and ST_WB writes
// the maximum to the end of the pass.
// Output channel (out_*): one result per kept value, ascending, one per cycle
// once started, while out_tready is high (ST_OSTART primes the read), out_tlast
// on the final one, pass and comparison counts in out_tdata, drop flag in out_tuser.
// A stalled receiver holds the current result; the store read is frozen.
// Reset (rst_n low, synchronous) empties the set and clears the counts; the
// store itself is not cleared, as only entries of the current set are read.
`default_nettype none

module bubble_sort_counted
  import bsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // value[31:0]
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // sorted_value[31:0], pass_count[35:32],
                                                 // compare_count[42:36], zeros above
  output logic                       out_tlast,
  output logic                       out_tuser   // overflow
);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_PSTART = 3'd1;
  localparam logic [2:0] ST_FIRST  = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_WB     = 3'd4;
  localparam logic [2:0] ST_OSTART = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       drop_r, drop_nxt;
  pass_t      pass_r, pass_nxt;
  cmp_t       cmp_r, cmp_nxt;
  idx_t       end_r, end_nxt;
  idx_t       pos_r, pos_nxt;
  val_t       carry_r, carry_nxt;

  logic       wr_en;
  idx_t       wr_addr;
  val_t       wr_data;
  logic       rd_en;
  idx_t       rd_addr;
  logic [VAL_W-1:0] rd_raw;
  val_t       rd_data;

  logic       in_acc;
  logic       full;
  cnt_t       n_set;
  logic       gt;
  logic       out_is_last;

  assign rd_data     = val_t'(rd_raw);
  assign in_acc      = in_tvalid && in_tready;
  assign full        = (cnt_r >= CNT_W'(MAX_ELEMENTS));
  assign n_set       = full ? cnt_r : cnt_r + CNT_W'(1);
  assign gt          = (carry_r > rd_data);
  assign out_is_last = ((CNT_W'(pos_r) + CNT_W'(1)) == cnt_r);

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = out_is_last;
  assign out_tuser  = drop_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, cmp_r, pass_r, rd_raw};

  bsc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    pass_nxt  = pass_r;
    cmp_nxt   = cmp_r;
    end_nxt   = end_r;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = carry_r;
    rd_en     = 1'b0;
    rd_addr   = pos_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[IDX_W-1:0];
            wr_data = val_t'(in_tdata[VAL_W-1:0]);
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            pass_nxt = '0;
            cmp_nxt  = '0;
            pos_nxt  = '0;
            if (n_set >= CNT_W'(2)) begin
              end_nxt   = IDX_W'(n_set - CNT_W'(1));
              state_nxt = ST_PSTART;
            end else begin
              state_nxt = ST_OSTART;
            end
          end
        end
      end
      ST_PSTART: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ST_FIRST;
      end
      ST_FIRST: begin
        carry_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = IDX_W'(1);
        pos_nxt   = IDX_W'(1);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r - IDX_W'(1);
        wr_data   = gt ? rd_data : carry_r;
        carry_nxt = gt ? carry_r : rd_data;
        if (cmp_r != '1) begin
          cmp_nxt = cmp_r + CMP_W'(1);
        end
        if (pos_r == end_r) begin
          state_nxt = ST_WB;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_r + IDX_W'(1);
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      ST_WB: begin
        wr_en   = 1'b1;
        wr_addr = end_r;
        wr_data = carry_r;
        end_nxt = end_r - IDX_W'(1);
        if (pass_r != '1) begin
          pass_nxt = pass_r + PASS_W'(1);
        end
        if (end_r == IDX_W'(1)) begin
          state_nxt = ST_OSTART;
        end else begin
          state_nxt = ST_PSTART;
        end
      end
      ST_OSTART: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        pos_nxt   = '0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          if (out_is_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_r + IDX_W'(1);
            pos_nxt = pos_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      pass_r  <= '0;
      cmp_r   <= '0;
      end_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      pass_r  <= pass_nxt;
      cmp_r   <= cmp_nxt;
      end_r   <= end_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

endmodule

`default_nettype wire

// ----- src/bsc_ram.sv -----
`default_nettype none

module bsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sim/bubble_sort_counted_tb.sv -----
`timescale 1ns / 100ps

module bubble_sort_counted_tb;
  import bsc_pkg::*;

  typedef struct packed {
    val_t  value;
    logic  last;
    pass_t passes;
    cmp_t  compares;
    logic  overflow;
  } sorted_item_t;

  typedef struct packed {
    val_t  value;
    logic  last;
    logic  typed;
    val_t  exp_value;
    pass_t exp_passes;
    cmp_t  exp_compares;
    logic  exp_overflow;
  } stim_row_t;

  localparam int NUM_ROWS = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;

  // Single-value sets carry a typed result; larger sets go through the predictor.
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 4'd0, 7'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 4'd0, 7'd0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 4'd0, 7'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 4'd0, 7'd0, 1'b0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'h0000_0003, 1'b1, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b0, 32'h0, 4'd0, 7'd0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  sorted_item_t pending_results[$];
  val_t         kept_values[$];
  logic         set_dropped = 1'b0;

  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned failures = 0;
  int unsigned sets_sorted = 0;
  int unsigned overflow_sets = 0;
  int unsigned values_checked = 0;

  bubble_sort_counted DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  task automatic predict_sort(input val_t v, input logic is_last);
    val_t         work [$];
    val_t         t;
    int           n;
    int           passes;
    int           compares;
    sorted_item_t res;
    if (kept_values.size() < MAX_ELEMENTS) begin
      kept_values.push_back(v);
    end else begin
      set_dropped = 1'b1;
    end
    if (!is_last) return;
    work = kept_values;
    n = work.size();
    passes = 0;
    compares = 0;
    for (int p = 0; p + 1 < n; p++) begin
      passes = (passes < 15) ? passes + 1 : 15;
      for (int i = 0; i + 1 < n - p; i++) begin
        compares = (compares < 127) ? compares + 1 : 127;
        if (work[i] > work[i+1]) begin
          t = work[i];
          work[i] = work[i+1];
          work[i+1] = t;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      res.value    = work[k];
      res.last     = (k + 1 == n);
      res.passes   = pass_t'(passes);
      res.compares = cmp_t'(compares);
      res.overflow = set_dropped;
      pending_results.push_back(res);
    end
    sets_sorted++;
    if (set_dropped) overflow_sets++;
    kept_values.delete();
    set_dropped = 1'b0;
  endtask

  task automatic offer_value(input val_t v, input logic is_last);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= is_last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    predict_sort(v, is_last);
  endtask

  function automatic val_t pick_value();
    if ($urandom_range(0, 3) == 0) return val_t'($urandom_range(0, 6)) - 3;
    return val_t'($urandom);
  endfunction

  task automatic check_result();
    sorted_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: value %0d", $signed(out_tdata[31:0]));
      failures++;
      return;
    end
    want = pending_results.pop_front();
    values_checked++;
    if (out_tdata[31:0] !== want.value) begin
      $error("sorted_value: expected %0d, got %0d", want.value, $signed(out_tdata[31:0]));
      failures++;
    end
    if (out_tlast !== want.last) begin
      $error("last_out: expected %0d, got %0d", want.last, out_tlast);
      failures++;
    end
    if (out_tdata[35:32] !== want.passes) begin
      $error("pass_count: expected %0d, got %0d", want.passes, out_tdata[35:32]);
      failures++;
    end
    if (out_tdata[42:36] !== want.compares) begin
      $error("compare_count: expected %0d, got %0d", want.compares, out_tdata[42:36]);
      failures++;
    end
    if (out_tuser !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, out_tuser);
      failures++;
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_result();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 31);
      end
    end
  end

  initial begin
    int        sent;
    int        set_idx;
    int        set_len;
    stim_row_t row;
    sorted_item_t typed_res;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      offer_value(row.value, row.last);
      if (row.typed) begin
        typed_res = '{row.exp_value, 1'b1, row.exp_passes, row.exp_compares,
                      row.exp_overflow};
        void'(pending_results.pop_back());
        pending_results.push_back(typed_res);
      end
    end

    // hold the sender until the directed sets have drained
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    sent = 0;
    set_idx = 0;
    while (sent < 100) begin
      case (set_idx)
        0:       set_len = 17;
        1:       set_len = MAX_ELEMENTS;
        2:       set_len = 18;
        default: set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                      : $urandom_range(1, 6);
      endcase
      if (set_idx == 3) hold_req = 1'b1;
      for (int k = 0; k < set_len; k++) begin
        no_idle = (sent >= 50 && sent < 75);
        offer_value(pick_value(), k == set_len - 1);
        sent++;
      end
      set_idx++;
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += pending_results.size();

    $display("sorted %0d sets (%0d with dropped values), %0d results checked",
             sets_sorted, overflow_sets, values_checked);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
